[rtl/pclb_pkg.sv]
package pclb_pkg;

  // defaults of the top-level parameters
  localparam int MESH_DIM_DEF      = 16;
  localparam int MAX_PARTICLES_DEF = 4096;

  // fixed field widths
  localparam int POS_W   = 32;
  localparam int CELL_W  = 4;
  localparam int REF_W   = 12;
  localparam int CNT_W   = 13;
  localparam int MESH_W  = 5;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int EFF_W   = 7;   // clamped mesh size, holds up to 127

  localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

  // config reset values
  localparam logic [POS_W-1:0]  INV_RESET  = 32'h0001_0000;
  localparam logic [MESH_W-1:0] MESH_RESET = 5'd16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_FOLLOW = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X  = 3'd0,
    CFG_MIN_Y  = 3'd1,
    CFG_MIN_Z  = 3'd2,
    CFG_INV    = 3'd3,
    CFG_MESH_X = 3'd4,
    CFG_MESH_Y = 3'd5,
    CFG_MESH_Z = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_LOOK,
    S_DONE
  } state_t;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;

  typedef struct packed {
    logic       capture;    // take the input transaction
    logic       diff;       // register position minus minimum, all axes
    logic       mul;        // one axis through the multiplier
    logic [1:0] axis;
    logic       look;       // range checks, memory read
    logic       emit;       // update store, load result register
    logic       clr_start;
    logic       clr_step;   // write one empty cell
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/pclb_in_if.sv]
interface pclb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [3:0]  cell_x;
  logic [3:0]  cell_y;
  logic [3:0]  cell_z;
  logic [11:0] particle_ref;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, particle_ref,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, particle_ref,
    output ready
  );
endinterface

[rtl/pclb_out_if.sv]
interface pclb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] particle_out;
  logic [12:0] cell_count;

  modport source (
    output valid, status, particle_out, cell_count,
    input  ready
  );
  modport sink (
    input  valid, status, particle_out, cell_count,
    output ready
  );
endinterface

[rtl/pclb_ctrl.sv]
module pclb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pclb_pkg::action_t  in_action,
  output logic               in_ready,
  input  pclb_pkg::sts_t     sts,
  output pclb_pkg::cmd_t     cmd
);

  pclb_pkg::state_t state_r, state_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic             clr_res_r, clr_res_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == pclb_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pclb_pkg::S_CLEAR;
      axis_r    <= pclb_pkg::AXIS_X;
      clr_res_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      axis_r    <= axis_nxt;
      clr_res_r <= clr_res_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    axis_nxt    = axis_r;
    clr_res_nxt = clr_res_r;
    unique case (state_r)
      pclb_pkg::S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = clr_res_r ? pclb_pkg::S_DONE : pclb_pkg::S_IDLE;
        end
      end
      pclb_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            pclb_pkg::ACT_INSERT: state_nxt = pclb_pkg::S_DIFF;
            pclb_pkg::ACT_QUERY,
            pclb_pkg::ACT_FOLLOW: state_nxt = pclb_pkg::S_LOOK;
            pclb_pkg::ACT_CLEAR: begin
              state_nxt   = pclb_pkg::S_CLEAR;
              clr_res_nxt = 1'b1;
            end
            default: state_nxt = pclb_pkg::S_IDLE;
          endcase
        end
      end
      pclb_pkg::S_DIFF: begin
        state_nxt = pclb_pkg::S_MUL;
        axis_nxt  = pclb_pkg::AXIS_X;
      end
      pclb_pkg::S_MUL: begin
        axis_nxt = axis_r + 2'd1;
        if (axis_r == pclb_pkg::AXIS_Z) begin
          state_nxt = pclb_pkg::S_LOOK;
        end
      end
      pclb_pkg::S_LOOK: state_nxt = pclb_pkg::S_DONE;
      pclb_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_nxt   = pclb_pkg::S_IDLE;
          clr_res_nxt = 1'b0;
        end
      end
      default: state_nxt = pclb_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.axis      = axis_r;
    unique case (state_r)
      pclb_pkg::S_CLEAR: cmd.clr_step = 1'b1;
      pclb_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = accept;
        cmd.clr_start = accept && (in_action == pclb_pkg::ACT_CLEAR);
      end
      pclb_pkg::S_DIFF: cmd.diff = 1'b1;
      pclb_pkg::S_MUL:  cmd.mul  = 1'b1;
      pclb_pkg::S_LOOK: cmd.look = 1'b1;
      pclb_pkg::S_DONE: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/pclb_dp.sv]
module pclb_dp #(
  parameter int MESH_DIM      = pclb_pkg::MESH_DIM_DEF,
  parameter int MAX_PARTICLES = pclb_pkg::MAX_PARTICLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pclb_pkg::cmd_t                  cmd,
  output pclb_pkg::sts_t                  sts,
  input  logic [1:0]                      in_action,
  input  logic [pclb_pkg::POS_W-1:0]      in_pos_x,
  input  logic [pclb_pkg::POS_W-1:0]      in_pos_y,
  input  logic [pclb_pkg::POS_W-1:0]      in_pos_z,
  input  logic [pclb_pkg::CELL_W-1:0]     in_cell_x,
  input  logic [pclb_pkg::CELL_W-1:0]     in_cell_y,
  input  logic [pclb_pkg::CELL_W-1:0]     in_cell_z,
  input  logic [pclb_pkg::REF_W-1:0]      in_particle_ref,
  input  logic                            cfg_we,
  input  logic [pclb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pclb_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [pclb_pkg::REF_W-1:0]      out_particle,
  output logic [pclb_pkg::CNT_W-1:0]      out_count
);

  localparam int NCELLS = MESH_DIM * MESH_DIM * MESH_DIM;
  localparam int AW     = $clog2(NCELLS);
  localparam int PW     = $clog2(MAX_PARTICLES);
  localparam int LW     = PW + 1;
  localparam int CW     = 1 + pclb_pkg::CNT_W + PW;   // valid, count, head
  localparam int NW     = 1 + PW;                     // valid, link
  localparam int PWS    = pclb_pkg::POS_W;
  localparam int EW     = pclb_pkg::EFF_W;

  // config registers
  logic [PWS-1:0]              min_r [3];
  logic [PWS-1:0]              inv_r;
  logic [pclb_pkg::MESH_W-1:0] mesh_r [3];

  // captured transaction
  pclb_pkg::action_t           act_r;
  logic [PWS-1:0]              pos_r [3];
  logic [pclb_pkg::CELL_W-1:0] cell_r [3];
  logic [pclb_pkg::REF_W-1:0]  ref_r;

  // axis arithmetic
  logic [PWS-1:0]   dist_r [3];
  logic             neg_r  [3];
  logic [PWS-1:0]   coord_r [3];
  logic [2*PWS-1:0] prod;

  // store
  logic [CW-1:0] cell_mem [NCELLS];
  logic [NW-1:0] next_mem [MAX_PARTICLES];
  logic [CW-1:0] rd_cell_r;
  logic [NW-1:0] rd_next_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] clr_cnt_r;
  logic [LW-1:0] loaded_r;
  pclb_pkg::status_t look_st_r, look_st;

  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [pclb_pkg::REF_W-1:0]  out_particle_r;
  logic [pclb_pkg::CNT_W-1:0]  out_count_r;

  // look stage signals
  logic [EW-1:0] eff [3];
  logic [EW-1:0] crd [3];
  logic [31:0]   addr_wide;
  logic [AW-1:0] cell_addr;
  logic          ins_inside, q_outside, full, unknown;
  logic [31:0]   ref32;
  logic [PW-1:0] ref_idx;

  // done stage signals
  logic                        rd_valid, n_valid;
  logic [pclb_pkg::CNT_W-1:0]  rd_cnt, cnt_new;
  logic [PW-1:0]               rd_head, n_link, pidx;
  logic [31:0]                 head32, link32, pidx32;
  logic                        ins_ok;
  logic                        cell_we;
  logic [AW-1:0]               cell_waddr;
  logic [CW-1:0]               cell_wdata;
  logic [1:0]                  res_status;
  logic [pclb_pkg::REF_W-1:0]  res_particle;
  logic [pclb_pkg::CNT_W-1:0]  res_count;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r[0]  <= '0;
      min_r[1]  <= '0;
      min_r[2]  <= '0;
      inv_r     <= pclb_pkg::INV_RESET;
      mesh_r[0] <= pclb_pkg::MESH_RESET;
      mesh_r[1] <= pclb_pkg::MESH_RESET;
      mesh_r[2] <= pclb_pkg::MESH_RESET;
    end else if (cfg_we) begin
      unique case (pclb_pkg::cfg_idx_t'(cfg_index))
        pclb_pkg::CFG_MIN_X:  min_r[0]  <= cfg_wdata;
        pclb_pkg::CFG_MIN_Y:  min_r[1]  <= cfg_wdata;
        pclb_pkg::CFG_MIN_Z:  min_r[2]  <= cfg_wdata;
        pclb_pkg::CFG_INV:    inv_r     <= cfg_wdata;
        pclb_pkg::CFG_MESH_X: mesh_r[0] <= cfg_wdata[pclb_pkg::MESH_W-1:0];
        pclb_pkg::CFG_MESH_Y: mesh_r[1] <= cfg_wdata[pclb_pkg::MESH_W-1:0];
        pclb_pkg::CFG_MESH_Z: mesh_r[2] <= cfg_wdata[pclb_pkg::MESH_W-1:0];
        default: ;
      endcase
    end
  end

  // capture, differences, shared multiplier
  assign prod = 64'(dist_r[cmd.axis]) * 64'(inv_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r     <= pclb_pkg::action_t'(in_action);
      pos_r[0]  <= in_pos_x;
      pos_r[1]  <= in_pos_y;
      pos_r[2]  <= in_pos_z;
      cell_r[0] <= in_cell_x;
      cell_r[1] <= in_cell_y;
      cell_r[2] <= in_cell_z;
      ref_r     <= in_particle_ref;
    end
    if (cmd.diff) begin
      for (int k = 0; k < 3; k++) begin
        {neg_r[k], dist_r[k]} <= {pos_r[k][PWS-1], pos_r[k]} - {min_r[k][PWS-1], min_r[k]};
      end
    end
    if (cmd.mul) begin
      coord_r[cmd.axis] <= prod[2*PWS-1:PWS];
    end
  end

  // range checks and cell address
  always_comb begin
    ins_inside = 1'b1;
    q_outside  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      eff[k] = (EW'(mesh_r[k]) > EW'(MESH_DIM)) ? EW'(MESH_DIM) : EW'(mesh_r[k]);
      ins_inside = ins_inside && !neg_r[k] && (coord_r[k] < 32'(eff[k]));
      q_outside  = q_outside || (EW'(cell_r[k]) >= eff[k]);
      crd[k] = (act_r == pclb_pkg::ACT_INSERT) ? coord_r[k][EW-1:0] : EW'(cell_r[k]);
    end
    addr_wide = 32'(crd[0]) * 32'(MESH_DIM * MESH_DIM) + 32'(crd[1]) * 32'(MESH_DIM)
              + 32'(crd[2]);
    cell_addr = addr_wide[AW-1:0];
    full      = loaded_r >= LW'(MAX_PARTICLES);
    ref32     = 32'(ref_r);
    ref_idx   = ref32[PW-1:0];
    unknown   = (ref32 >= 32'(loaded_r)) || (ref32 >= 32'(MAX_PARTICLES));
    unique case (act_r)
      pclb_pkg::ACT_INSERT:
        look_st = !ins_inside ? pclb_pkg::STAT_OUTSIDE :
                  full ? pclb_pkg::STAT_FULL : pclb_pkg::STAT_OK;
      pclb_pkg::ACT_QUERY:
        look_st = q_outside ? pclb_pkg::STAT_OUTSIDE : pclb_pkg::STAT_OK;
      pclb_pkg::ACT_FOLLOW:
        look_st = unknown ? pclb_pkg::STAT_FULL : pclb_pkg::STAT_OK;
      default: look_st = pclb_pkg::STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      look_st_r <= look_st;
      addr_r    <= cell_addr;
      rd_cell_r <= cell_mem[cell_addr];
      rd_next_r <= next_mem[ref_idx];
    end
  end

  // result and store update
  always_comb begin
    rd_valid = rd_cell_r[CW-1];
    rd_cnt   = rd_cell_r[PW+pclb_pkg::CNT_W-1:PW];
    rd_head  = rd_cell_r[PW-1:0];
    n_valid  = rd_next_r[NW-1];
    n_link   = rd_next_r[PW-1:0];
    pidx     = loaded_r[PW-1:0];
    head32   = 32'(rd_head);
    link32   = 32'(n_link);
    pidx32   = 32'(pidx);
    cnt_new  = (rd_cnt == pclb_pkg::CNT_MAX) ? rd_cnt : rd_cnt + 13'd1;
    ins_ok   = (act_r == pclb_pkg::ACT_INSERT) && (look_st_r == pclb_pkg::STAT_OK);

    res_status   = look_st_r;
    res_particle = '0;
    res_count    = '0;
    if (look_st_r == pclb_pkg::STAT_OK) begin
      unique case (act_r)
        pclb_pkg::ACT_INSERT: begin
          res_particle = pidx32[pclb_pkg::REF_W-1:0];
          res_count    = cnt_new;
        end
        pclb_pkg::ACT_QUERY: begin
          if (!rd_valid) begin
            res_status = pclb_pkg::STAT_EMPTY;
          end else begin
            res_particle = head32[pclb_pkg::REF_W-1:0];
            res_count    = rd_cnt;
          end
        end
        pclb_pkg::ACT_FOLLOW: begin
          if (!n_valid) begin
            res_status = pclb_pkg::STAT_EMPTY;
          end else begin
            res_particle = link32[pclb_pkg::REF_W-1:0];
          end
        end
        default: res_status = pclb_pkg::STAT_OK;
      endcase
    end
    if (act_r == pclb_pkg::ACT_CLEAR) begin
      res_status = pclb_pkg::STAT_OK;
    end

    cell_we    = cmd.clr_step || (cmd.emit && ins_ok);
    cell_waddr = cmd.clr_step ? clr_cnt_r : addr_r;
    cell_wdata = cmd.clr_step ? '0 : {1'b1, cnt_new, pidx};
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cmd.emit && ins_ok) begin
      next_mem[pidx] <= {rd_valid, rd_valid ? rd_head : PW'(0)};
    end
  end

  // clearing sweep and particle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      loaded_r  <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.emit && (act_r == pclb_pkg::ACT_CLEAR)) begin
        loaded_r <= '0;
      end else if (cmd.emit && ins_ok) begin
        loaded_r <= loaded_r + LW'(1);
      end
    end
  end

  assign sts.clr_last = (clr_cnt_r == AW'(NCELLS - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r   <= res_status;
      out_particle_r <= res_particle;
      out_count_r    <= res_count;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_particle = out_particle_r;
  assign out_count    = out_count_r;

endmodule

[rtl/particle_cell_list_binner_core.sv]
// Linked cell list binner: sorts 3D particle positions (signed Q16.16) into a
// grid of up to MESH_DIM^3 cells, each cell a singly linked list of particle
// indices. One transaction in gives exactly one result out. Items are handled
// one at a time: an insert steps through accept, subtract, three passes of
// the one shared 32x32 multiplier, range check with cell memory read and
// update before the next ready; a cell query or a follow query steps through
// accept, registered memory read and result; and a clear writes every cell
// entry of the cell memory once, one per cycle, before its result. After
// reset the same sweep runs over all MESH_DIM^3 cells (4096 with the default
// mesh) with in_ch.ready low; configuration writes are taken at any time
// but are meant to happen only while the block is idle.
// A result waits in an output register, so the block goes on with the next
// item until a second result would need that register.
module particle_cell_list_binner_core #(
  parameter int MESH_DIM      = pclb_pkg::MESH_DIM_DEF,
  parameter int MAX_PARTICLES = pclb_pkg::MAX_PARTICLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pclb_in_if.sink                        in_ch,
  pclb_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pclb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pclb_pkg::CFG_W-1:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  pclb_pkg::cmd_t cmd;
  pclb_pkg::sts_t sts;

  // sequencer: clearing sweep, insert steps, lookups, result handoff
  pclb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (pclb_pkg::action_t'(in_ch.action)),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: config registers, cell and link memories, result register
  pclb_dp #(
    .MESH_DIM      (MESH_DIM),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_ch.action),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_pos_z        (in_ch.pos_z),
    .in_cell_x       (in_ch.cell_x),
    .in_cell_y       (in_ch.cell_y),
    .in_cell_z       (in_ch.cell_z),
    .in_particle_ref (in_ch.particle_ref),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_particle    (out_ch.particle_out),
    .out_count       (out_ch.cell_count)
  );

endmodule
